FILE: rtl/core/sli_pkg.sv
// Shared types and constants for the sorted list insert/delete block.
package sli_pkg;

  localparam int unsigned CAPACITY_DEF = 16;
  localparam int unsigned VALUE_W      = 32;
  localparam int unsigned COUNT_W      = 5;
  localparam int unsigned STATUS_W     = 2;
  localparam int unsigned OP_W         = 2;
  localparam int unsigned S_TDATA_W    = 32;
  localparam int unsigned M_TDATA_W    = 40;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT  = 2'd0,
    OP_DELETE  = 2'd1,
    OP_DISPLAY = 2'd2
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_FULL     = 2'd1,
    STATUS_NOTFOUND = 2'd2,
    STATUS_EMPTY    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_DELETE = 2'd2,
    CELL_ROTATE = 2'd3
  } cell_op_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_DISP = 1'b1
  } state_e;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    cell_op_e                   op;
    logic signed [VALUE_W-1:0]  value;
  } sli_cmd_t;

  // Per-cell compare results back to the controller.
  typedef struct packed {
    logic lt;
    logic match;
  } sli_cell_stat_t;

endpackage

FILE: rtl/core/sli_cell.sv
// One storage cell of the sorted chain: holds an entry and shifts with its neighbors.
module sli_cell import sli_pkg::*; (
  input  logic                       clk_i,
  input  sli_cmd_t                   cmd_i,
  input  logic                       valid_i,
  input  logic                       prev_lt_i,
  input  logic signed [VALUE_W-1:0]  prev_value_i,
  input  logic                       next_valid_i,
  input  logic signed [VALUE_W-1:0]  next_value_i,
  input  logic signed [VALUE_W-1:0]  head_value_i,
  output logic signed [VALUE_W-1:0]  value_o,
  output sli_cell_stat_t             stat_o
);

  logic signed [VALUE_W-1:0] value_q, value_d;
  logic                      lt;

  assign lt           = valid_i && (value_q < cmd_i.value);
  assign stat_o.lt    = lt;
  assign stat_o.match = valid_i && (value_q == cmd_i.value);
  assign value_o      = value_q;

  always_comb begin
    value_d = value_q;
    case (cmd_i.op)
      CELL_INSERT: begin
        // keep smaller entries, open the gap right after the last one
        if (!lt) begin
          value_d = prev_lt_i ? cmd_i.value : prev_value_i;
        end
      end
      CELL_DELETE: begin
        // entries at or above the victim close the gap
        if (valid_i && !lt) begin
          value_d = next_value_i;
        end
      end
      CELL_ROTATE: begin
        if (next_valid_i) begin
          value_d = next_value_i;
        end else if (valid_i) begin
          value_d = head_value_i;
        end
      end
      default: begin
        value_d = value_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

endmodule

FILE: rtl/core/sorted_list_insert_delete.sv
// Top level of the sorted list: cell chain, command control and output register.
//
//  channel   | dir | tdata                                   | tuser         | tlast
//  ----------+-----+-----------------------------------------+---------------+-------------
//  s_axis    | in  | value[31:0]                             | operation[1:0]| -
//  m_axis    | out | value_out[31:0], count[36:32], zero pad | status[1:0]   | last
//
// On insert and delete every cell compares its entry against the
// beat's value at once and the whole chain shifts in that same edge.
// Display first moves the control into its display state; then the chain
// rotates by one position per beat into the output register, so after count
// beats the list is back in place. The input is held off during a display.
// Reset clears the entry count and the control; entry values are not reset.
// A stalled output holds the chain and the input until the beat is taken.
module sorted_list_insert_delete import sli_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // slave side
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  logic [S_TDATA_W-1:0]   s_axis_tdata_i,   // [31:0] value
  input  logic [OP_W-1:0]        s_axis_tuser_i,   // [1:0] operation
  // master side
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  output logic [M_TDATA_W-1:0]   m_axis_tdata_o,   // [31:0] value_out, [36:32] count
  output logic [STATUS_W-1:0]    m_axis_tuser_o,   // [1:0] status
  output logic                   m_axis_tlast_o
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  // chain wiring
  sli_cmd_t                   cmd;
  logic signed [VALUE_W-1:0]  cell_value [CAPACITY];
  sli_cell_stat_t             cell_stat  [CAPACITY];
  logic [CAPACITY-1:0]        cell_valid;
  logic [CAPACITY-1:0]        cell_match;

  // control
  state_e                     state_q, state_d;
  logic [CNT_W-1:0]           count_q, count_d;
  logic [CNT_W-1:0]           left_q, left_d;

  // output register
  logic                       out_valid_q, out_valid_d;
  logic signed [VALUE_W-1:0]  out_value_q, out_value_d;
  logic                       out_last_q, out_last_d;
  status_e                    out_status_q, out_status_d;
  logic [CNT_W-1:0]           out_count_q, out_count_d;

  logic                       out_free;
  logic                       s_accept;
  logic                       found;
  logic                       full;
  op_e                        op;

  // the chain
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    // occupancy comes from the count, so no per-entry valid flop
    assign cell_valid[i] = count_q > CNT_W'(i);
    assign cell_match[i] = cell_stat[i].match;

    if (i == 0) begin : g_head
      sli_cell u_cell (
        .clk_i        (clk_i),
        .cmd_i        (cmd),
        .valid_i      (cell_valid[i]),
        .prev_lt_i    (1'b1),
        .prev_value_i ('0),
        .next_valid_i (cell_valid[i+1]),
        .next_value_i (cell_value[i+1]),
        .head_value_i (cell_value[0]),
        .value_o      (cell_value[i]),
        .stat_o       (cell_stat[i])
      );
    end else if (i == CAPACITY - 1) begin : g_tail
      sli_cell u_cell (
        .clk_i        (clk_i),
        .cmd_i        (cmd),
        .valid_i      (cell_valid[i]),
        .prev_lt_i    (cell_stat[i-1].lt),
        .prev_value_i (cell_value[i-1]),
        .next_valid_i (1'b0),
        .next_value_i ('0),
        .head_value_i (cell_value[0]),
        .value_o      (cell_value[i]),
        .stat_o       (cell_stat[i])
      );
    end else begin : g_mid
      sli_cell u_cell (
        .clk_i        (clk_i),
        .cmd_i        (cmd),
        .valid_i      (cell_valid[i]),
        .prev_lt_i    (cell_stat[i-1].lt),
        .prev_value_i (cell_value[i-1]),
        .next_valid_i (cell_valid[i+1]),
        .next_value_i (cell_value[i+1]),
        .head_value_i (cell_value[0]),
        .value_o      (cell_value[i]),
        .stat_o       (cell_stat[i])
      );
    end
  end

  assign found    = |cell_match;
  assign full     = count_q == CNT_W'(CAPACITY);
  assign op       = op_e'(s_axis_tuser_i);
  assign out_free = !out_valid_q || m_axis_tready_i;

  // take a new beat only between displays and with room in the output register
  assign s_axis_tready_o = (state_q == S_IDLE) && out_free;
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    left_d       = left_q;
    cmd.op       = CELL_HOLD;
    cmd.value    = $signed(s_axis_tdata_i[VALUE_W-1:0]);
    out_valid_d  = out_valid_q && !m_axis_tready_i;
    out_value_d  = out_value_q;
    out_last_d   = out_last_q;
    out_status_d = out_status_q;
    out_count_d  = out_count_q;

    case (state_q)
      S_IDLE: begin
        if (s_accept) begin
          out_value_d = '0;
          out_last_d  = 1'b1;
          case (op)
            OP_INSERT: begin
              out_valid_d = 1'b1;
              if (full) begin
                out_status_d = STATUS_FULL;
                out_count_d  = count_q;
              end else begin
                cmd.op       = CELL_INSERT;
                count_d      = count_q + 1'b1;
                out_status_d = STATUS_OK;
                out_count_d  = count_q + 1'b1;
              end
            end
            OP_DELETE: begin
              out_valid_d = 1'b1;
              if (found) begin
                cmd.op       = CELL_DELETE;
                count_d      = count_q - 1'b1;
                out_status_d = STATUS_OK;
                out_count_d  = count_q - 1'b1;
              end else begin
                out_status_d = STATUS_NOTFOUND;
                out_count_d  = count_q;
              end
            end
            OP_DISPLAY: begin
              if (count_q == '0) begin
                out_valid_d  = 1'b1;
                out_status_d = STATUS_EMPTY;
                out_count_d  = count_q;
              end else begin
                left_d  = count_q;
                state_d = S_DISP;
              end
            end
            default: begin
              // unused code: drop the beat
              out_valid_d = out_valid_q && !m_axis_tready_i;
            end
          endcase
        end
      end
      S_DISP: begin
        // emit the head and rotate the chain by one
        if (out_free) begin
          cmd.op       = CELL_ROTATE;
          out_valid_d  = 1'b1;
          out_value_d  = cell_value[0];
          out_last_d   = left_q == CNT_W'(1);
          out_status_d = STATUS_OK;
          out_count_d  = count_q;
          left_d       = left_q - 1'b1;
          if (left_q == CNT_W'(1)) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      left_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      left_q      <= left_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_value_q  <= out_value_d;
    out_last_q   <= out_last_d;
    out_status_q <= out_status_d;
    out_count_q  <= out_count_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tuser_o  = out_status_q;
  assign m_axis_tdata_o  = {{(M_TDATA_W - VALUE_W - COUNT_W){1'b0}},
                            COUNT_W'(out_count_q), out_value_q};

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------

  // occupancy never passes the capacity
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  // no new beat is taken while a display is streaming
  a_disp_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DISP) |-> !s_axis_tready_o)
    else $error("input accepted during display");

  // a successful insert grows the list by exactly one
  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_accept && (op == OP_INSERT) && !full) |=> (count_q == $past(count_q) + 1'b1))
    else $error("insert did not grow the list");

  // the count does not move while a display streams
  a_disp_count_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DISP) |=> $stable(count_q))
    else $error("count changed during display");

endmodule

FILE: sim/testbench.sv
// Self-checking testbench for the sorted list insert/delete block.
`timescale 1ns / 100ps

module testbench;
  import sli_pkg::*;

  // Operation code the block must ignore: no beat out, list untouched.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  localparam int unsigned MAX_WAIT       = 13;    // longest sender gap / receiver stall
  localparam int unsigned WATCHDOG_LIMIT = 2000;  // cycles with no input beat taken
  localparam int unsigned DRAIN_CYCLES   = 40;    // settle time after the last result

  // One result beat as the block should produce it.
  typedef struct packed {
    logic signed [VALUE_W-1:0] value_out;
    logic                      last;
    status_e                   status;
    logic [COUNT_W-1:0]        count;
  } list_beat_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid_i;
  logic                 s_axis_tready_o;
  logic [S_TDATA_W-1:0] s_axis_tdata_i;   // [31:0] value
  logic [OP_W-1:0]      s_axis_tuser_i;   // [1:0] operation
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i;
  logic [M_TDATA_W-1:0] m_axis_tdata_o;   // [31:0] value_out, [36:32] count, [39:37] zero
  logic [STATUS_W-1:0]  m_axis_tuser_o;   // [1:0] status
  logic                 m_axis_tlast_o;

  // Mirror of the list contents, kept in ascending signed order.
  logic signed [VALUE_W-1:0] held[$];
  // Result beats predicted but not yet seen on the master side, oldest first.
  list_beat_t                beats_due[$];

  bit          idling_on;
  int          errors;
  int unsigned stuck_cycles;
  int unsigned n_insert, n_full, n_delete, n_miss, n_display, n_ignored, n_beats;

  sorted_list_insert_delete #(
    .CAPACITY(CAPACITY_DEF)
  ) dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid_i,
    .s_axis_tready_o,
    .s_axis_tdata_i,
    .s_axis_tuser_i,
    .m_axis_tvalid_o,
    .m_axis_tready_i,
    .m_axis_tdata_o,
    .m_axis_tuser_o,
    .m_axis_tlast_o
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // List predictor
  // ---------------------------------------------------------------------------

  // Queue one result beat; count reflects the list after the operation.
  function automatic void queue_beat(logic signed [VALUE_W-1:0] v, logic last,
                                     status_e st);
    list_beat_t b;
    b.value_out = v;
    b.last      = last;
    b.status    = st;
    b.count     = COUNT_W'(held.size());
    beats_due.push_back(b);
  endfunction

  // Apply one accepted input beat to the mirror and queue the beats it causes.
  function automatic void apply_list_op(logic [OP_W-1:0] op,
                                        logic signed [VALUE_W-1:0] value);
    int pos;
    pos = 0;
    case (op)
      OP_INSERT: begin
        n_insert++;
        if (held.size() >= CAPACITY_DEF) begin
          // full: drop the value, leave the list alone
          n_full++;
          queue_beat('0, 1'b1, STATUS_FULL);
        end else begin
          // skip every strictly smaller entry, so a new value goes ahead of equal entries
          while (pos < held.size() && held[pos] < value) pos++;
          held.insert(pos, value);
          queue_beat('0, 1'b1, STATUS_OK);
        end
      end
      OP_DELETE: begin
        n_delete++;
        while (pos < held.size() && held[pos] != value) pos++;
        if (pos >= held.size()) begin
          // no match, which covers an empty list too
          n_miss++;
          queue_beat('0, 1'b1, STATUS_NOTFOUND);
        end else begin
          held.delete(pos);
          queue_beat('0, 1'b1, STATUS_OK);
        end
      end
      OP_DISPLAY: begin
        n_display++;
        if (held.size() == 0) begin
          queue_beat('0, 1'b1, STATUS_EMPTY);
        end else begin
          for (int i = 0; i < held.size(); i++)
            queue_beat(held[i], i == held.size() - 1, STATUS_OK);
        end
      end
      default: begin
        n_ignored++;
      end
    endcase
  endfunction

  // Half the time a small pool around zero so duplicates and delete hits are common,
  // with values near both ends of the range and fully random patterns mixed in.
  function automatic logic signed [VALUE_W-1:0] random_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return $urandom_range(0, 9) - 5;
      5: begin
        if ($urandom_range(0, 1) != 0) return 32'h8000_0000 + $urandom_range(0, 3);
        else return 32'h7FFF_FFFF - $urandom_range(0, 3);
      end
      default: return $urandom();
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Slave side driver
  // ---------------------------------------------------------------------------

  // Present one beat from a falling edge, hold it until accepted, then draw the
  // gap before the next one. With no gap tvalid stays high across beats.
  task automatic send_item(input logic [OP_W-1:0] op,
                           input logic signed [VALUE_W-1:0] value);
    int unsigned gap;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= value;
    s_axis_tuser_i  <= op;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    apply_list_op(op, value);
    @(negedge clk_i);
    gap = idling_on ? $urandom_range(0, MAX_WAIT) : 0;
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Master side: random back-pressure, one stall draw per beat
  // ---------------------------------------------------------------------------

  initial begin
    int unsigned stall;
    m_axis_tready_i = 1'b0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      stall = idling_on ? $urandom_range(0, MAX_WAIT) : 0;
      if (stall != 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid_o) @(posedge clk_i);
      @(negedge clk_i);
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: compare every accepted beat with the oldest prediction
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin : check_beats
    list_beat_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (beats_due.size() == 0) begin
        $error("unexpected beat: value_out %0d status %0d count %0d last %0b",
               $signed(m_axis_tdata_o[31:0]), m_axis_tuser_o, m_axis_tdata_o[36:32],
               m_axis_tlast_o);
        errors++;
      end else begin
        want = beats_due.pop_front();
        n_beats++;
        if ($signed(m_axis_tdata_o[31:0]) != want.value_out) begin
          $error("value_out: expected %0d, got %0d", want.value_out,
                 $signed(m_axis_tdata_o[31:0]));
          errors++;
        end
        if (m_axis_tlast_o != want.last) begin
          $error("last: expected %0b, got %0b", want.last, m_axis_tlast_o);
          errors++;
        end
        if (m_axis_tuser_o != want.status) begin
          $error("status: expected %0d, got %0d", want.status, m_axis_tuser_o);
          errors++;
        end
        if (m_axis_tdata_o[36:32] != want.count) begin
          $error("count: expected %0d, got %0d", want.count, m_axis_tdata_o[36:32]);
          errors++;
        end
        if (m_axis_tdata_o[39:37] != '0) begin
          $error("pad: expected 0, got %0d", m_axis_tdata_o[39:37]);
          errors++;
        end
      end
    end
  end

  // Abort when no input beat is taken for too long; a block that streams
  // results forever without taking input trips this too.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no input beat for %0d cycles, %0d results outstanding",
               stuck_cycles, beats_due.size());
      $display("** sorted_list_insert_delete: FAILED **");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Exercise an empty list: empty display, delete with nothing held, ignored code.
  task automatic test_empty_list;
    send_item(OP_DISPLAY, 32'sd7);
    send_item(OP_DELETE, '0);
    send_item(OP_UNUSED, 32'h5555_AAAA);
    send_item(OP_DELETE, 32'h8000_0000);
    send_item(OP_UNUSED, 32'hAAAA_5555);
    send_item(OP_DISPLAY, '1);
  endtask

  // Insert the range ends, zero and duplicates, then remove from head, middle and
  // tail and miss once.
  task automatic test_extremes;
    send_item(OP_INSERT, 32'h8000_0000);
    send_item(OP_INSERT, 32'h7FFF_FFFF);
    send_item(OP_INSERT, '0);
    send_item(OP_INSERT, '1);
    send_item(OP_INSERT, '0);
    send_item(OP_INSERT, 32'sd1);
    send_item(OP_DISPLAY, '0);
    send_item(OP_DELETE, '1);
    send_item(OP_DELETE, 32'sd5);
    send_item(OP_DELETE, 32'h8000_0000);
    send_item(OP_DELETE, 32'h7FFF_FFFF);
    send_item(OP_DISPLAY, '0);
  endtask

  // Fill to capacity, overflow, read the full list back, then drain it in
  // random order down to a miss on the empty list.
  task automatic test_fill_and_overflow;
    idling_on = 1'b1;
    while (held.size() < CAPACITY_DEF) send_item(OP_INSERT, random_value());
    send_item(OP_INSERT, random_value());
    send_item(OP_INSERT, held[0]);
    send_item(OP_DISPLAY, random_value());
    while (held.size() != 0) send_item(OP_DELETE, held[$urandom_range(0, held.size() - 1)]);
    send_item(OP_DELETE, random_value());
    send_item(OP_DISPLAY, random_value());
  endtask

  // Random operations that swing the list between empty and full. Deletes mostly
  // target a held value; a few ignored codes and many displays are mixed in.
  task automatic test_random_mix(input int n_items, input bit allow_idle);
    bit                        grow;
    int unsigned               r;
    logic [OP_W-1:0]           op;
    logic signed [VALUE_W-1:0] v;
    grow = 1'b1;
    idling_on = allow_idle;
    for (int k = 0; k < n_items; k++) begin
      // switch idling per stretch so some runs go back to back
      if (allow_idle && k % 24 == 0) idling_on = ($urandom_range(0, 3) != 0);
      if (held.size() == 0) grow = 1'b1;
      else if (held.size() == CAPACITY_DEF && $urandom_range(0, 3) == 0) grow = 1'b0;
      else if ($urandom_range(0, 19) == 0) grow = !grow;
      r = $urandom_range(0, 99);
      if (r < 3) op = OP_UNUSED;
      else if (r < 12) op = OP_DISPLAY;
      else if (r < (grow ? 75 : 40)) op = OP_INSERT;
      else op = OP_DELETE;
      if (op == OP_DELETE && held.size() != 0 && $urandom_range(0, 3) != 0)
        v = held[$urandom_range(0, held.size() - 1)];
      else
        v = random_value();
      send_item(op, v);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = '0;
    idling_on       = 1'b1;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_empty_list();
    test_extremes();
    test_fill_and_overflow();
    test_random_mix(40, 1'b0);
    test_random_mix(240, 1'b1);

    // drop tvalid, then wait out every predicted beat and a quiet tail
    s_axis_tvalid_i <= 1'b0;
    while (beats_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d inserts (%0d on a full list), %0d deletes (%0d misses),",
             n_insert, n_full, n_delete, n_miss);
    $display("%0d displays and %0d ignored codes; %0d result beats checked, %0d errors",
             n_display, n_ignored, n_beats, errors);
    if (errors == 0) begin
      $display("** sorted_list_insert_delete: PASSED **");
    end else begin
      $display("** sorted_list_insert_delete: FAILED **");
    end
    $finish;
  end

endmodule

FILE: sorted_list_insert_delete.f
rtl/core/sli_pkg.sv
rtl/core/sli_cell.sv
rtl/core/sorted_list_insert_delete.sv
sim/testbench.sv
